/* rtl/core/hvt_pkg.sv */
// Package for the header value tokenizer: payload structs, character codes,
// status codes, register map and small helper functions. No dependencies.
`default_nettype none

package hvt_pkg;

  localparam int unsigned BUFFER_MAX = 4096;
  localparam int unsigned TOKENS_MAX = 1024;

  localparam int unsigned CNT_W   = 13;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned MAXT_W  = 11;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CNT_W-1:0]  CNT_SAT      = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0]  LEN_LIMIT    = LEN_W'(BUFFER_MAX);
  localparam logic [MAXT_W-1:0] MAXT_LIMIT   = MAXT_W'(TOKENS_MAX);
  localparam logic [LEN_W-1:0]  LEN_RESET    = LEN_W'(4096);
  localparam logic [MAXT_W-1:0] MAXT_RESET   = MAXT_W'(1024);

  localparam logic REG_BUFFER_LEN = 1'b0;
  localparam logic REG_MAX_TOKENS = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_UNBAL = 2'd1;
  localparam logic [1:0] STATUS_OVFL  = 2'd2;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       out_byte;
    logic             token_start;
    logic [1:0]       status;
    logic [CNT_W-1:0] token_count;
    logic             last;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_EQUALS) || (c == CH_DOT);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_SAT) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/header_value_tokenizer.sv */
// Header value tokenizer: turns header text, one byte per item, into a stream
// of NUL-ended tokens with token start flags and an end-of-text summary.
// Depends on hvt_pkg.
//
//   Channel   Ports                              Moves
//   input     in_valid, in_ready, in_data        one text byte or end mark
//   result    out_valid, out_ready, out_data     one buffer byte or summary
//   config    psel, penable, pwrite, paddr, ...  buffer_len, max_tokens
//
// An item is decoded in the cycle it is accepted and its results, up to three,
// are loaded into a three-entry result queue. The queue hands out one result
// per cycle whenever out_ready is high.
// A new item is taken when the queue is empty or its last result is being
// taken in the same cycle. Reset clears the tokenizer state and the queue and
// loads the register defaults. A stalled result channel holds the queue.
`default_nettype none

module header_value_tokenizer (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  hvt_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output hvt_pkg::result_t                 out_data,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [hvt_pkg::PADDR_W-1:0]      paddr,
  input  wire  [hvt_pkg::PDATA_W-1:0]      pwdata,
  output logic [hvt_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import hvt_pkg::*;

  logic [LEN_W-1:0]  buffer_len_r;
  logic [MAXT_W-1:0] max_tokens_r;

  logic             quotes_r, quotes_nxt;
  logic             esc_r, esc_nxt;
  logic             intok_r, intok_nxt;
  logic             startp_r, startp_nxt;
  logic             collapse_r, collapse_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] written_r, written_nxt;
  logic [CNT_W-1:0] tokens_r, tokens_nxt;

  result_t          queue_r [3];
  result_t          queue_nxt [3];
  logic [1:0]       qcnt_r, qcnt_nxt;

  logic [LEN_W-1:0] len_eff;
  logic [MAXT_W-1:0] max_eff;
  logic             full;
  logic [LEN_W-1:0] room;
  logic             tok_room;
  logic             cfg_we;
  logic             accept;
  logic             pop;

  logic [7:0]       c;
  logic             sp_w;
  logic             it_w;
  logic [CNT_W-1:0] tc_w;
  logic [CNT_W-1:0] tc_mid;
  logic             dflag;
  logic             delim_path;
  logic [1:0]       delim_idx;
  logic [1:0]       req_n;
  logic [7:0]       req_b [3];
  logic             req_f [3];
  logic [1:0]       nwr;
  logic [1:0]       res_n;
  result_t          res [3];
  logic [1:0]       status_w;
  logic             end_byte;

  // Configuration port.
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == REG_MAX_TOKENS) begin
      prdata = PDATA_W'(max_tokens_r);
    end else begin
      prdata = PDATA_W'(buffer_len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_len_r <= LEN_RESET;
      max_tokens_r <= MAXT_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_BUFFER_LEN) begin
        buffer_len_r <= pwdata[LEN_W-1:0];
      end else begin
        max_tokens_r <= pwdata[MAXT_W-1:0];
      end
    end
  end

  // Effective register values.
  always_comb begin
    if (buffer_len_r > LEN_LIMIT) begin
      len_eff = LEN_LIMIT;
    end else if (buffer_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else begin
      len_eff = buffer_len_r;
    end
    if (max_tokens_r > MAXT_LIMIT) begin
      max_eff = MAXT_LIMIT;
    end else begin
      max_eff = max_tokens_r;
    end
  end

  assign full     = written_r >= len_eff;
  assign room     = len_eff - written_r;
  assign tok_room = tokens_r < CNT_W'(max_eff);
  assign c        = in_data.in_byte;

  // Handshake and queue control.
  assign out_valid = qcnt_r != 2'd0;
  assign out_data  = queue_r[0];
  assign pop       = out_valid && out_ready;
  assign in_ready  = (qcnt_r == 2'd0) || ((qcnt_r == 2'd1) && out_ready);
  assign accept    = in_valid && in_ready;

  // Decode of one item against the current state.
  always_comb begin
    quotes_nxt   = quotes_r;
    esc_nxt      = esc_r;
    intok_nxt    = intok_r;
    startp_nxt   = startp_r;
    collapse_nxt = collapse_r;
    depth_nxt    = depth_r;
    written_nxt  = written_r;
    tokens_nxt   = tokens_r;
    sp_w         = startp_r;
    it_w         = intok_r;
    tc_w         = tokens_r;
    tc_mid       = intok_r ? sat_inc(tokens_r) : tokens_r;
    dflag        = tc_mid < CNT_W'(max_eff);
    delim_path   = 1'b0;
    delim_idx    = 2'd0;
    req_n        = 2'd0;
    req_b[0]     = CH_NUL;
    req_b[1]     = CH_NUL;
    req_b[2]     = CH_NUL;
    req_f[0]     = 1'b0;
    req_f[1]     = 1'b0;
    req_f[2]     = 1'b0;
    nwr          = 2'd0;
    res_n        = 2'd0;
    status_w     = STATUS_OK;
    end_byte     = 1'b0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end

    if (in_data.end_of_text) begin
      if (quotes_r || (depth_r != '0)) begin
        status_w = STATUS_UNBAL;
      end else if (({1'b0, written_r} + (CNT_W+1)'(1)) >= {1'b0, len_eff}) begin
        status_w = STATUS_OVFL;
      end else begin
        status_w = STATUS_OK;
        if (intok_r) begin
          end_byte = 1'b1;
          tc_w     = sat_inc(tokens_r);
        end
      end
      res[0].kind        = KIND_BYTE;
      res[0].out_byte    = CH_NUL;
      res[0].token_start = startp_r;
      res[0].last        = 1'b0;
      res[end_byte ? 1 : 0]             = '0;
      res[end_byte ? 1 : 0].kind        = KIND_SUMMARY;
      res[end_byte ? 1 : 0].status      = status_w;
      res[end_byte ? 1 : 0].token_count = tc_w;
      res[end_byte ? 1 : 0].last        = 1'b1;
      if (!end_byte) begin
        res[1] = '0;
      end
      res_n        = end_byte ? 2'd2 : 2'd1;
      quotes_nxt   = 1'b0;
      esc_nxt      = 1'b0;
      intok_nxt    = 1'b0;
      startp_nxt   = 1'b0;
      collapse_nxt = 1'b0;
      depth_nxt    = '0;
      written_nxt  = '0;
      tokens_nxt   = '0;
    end else if (!(collapse_r && is_ws(c))) begin
      collapse_nxt = 1'b0;
      if (!full) begin
        if (esc_r) begin
          if (!intok_r) begin
            sp_w = tok_room;
            it_w = 1'b1;
          end
          esc_nxt = 1'b0;
          if ((c == CH_BSLASH) || (c == CH_QUOTE)) begin
            req_n    = 2'd2;
            req_b[0] = CH_BSLASH;
            req_b[1] = c;
          end else begin
            req_n    = 2'd1;
            req_b[0] = c;
          end
        end else if ((c == CH_BSLASH) && quotes_r) begin
          esc_nxt = 1'b1;
        end else if ((c == CH_QUOTE) && (depth_r == '0)) begin
          quotes_nxt = !quotes_r;
          if (!intok_r) begin
            sp_w = tok_room;
            it_w = 1'b1;
          end
        end else if ((c == CH_LPAREN) && !quotes_r) begin
          depth_nxt = sat_inc(depth_r);
          if (!intok_r) begin
            sp_w = tok_room;
            it_w = 1'b1;
          end
          req_n    = 2'd1;
          req_b[0] = c;
        end else if ((c == CH_RPAREN) && !quotes_r) begin
          if (depth_r != '0) begin
            depth_nxt = depth_r - CNT_W'(1);
            if (depth_r == CNT_W'(1)) begin
              it_w     = 1'b0;
              tc_w     = sat_inc(tokens_r);
              req_n    = 2'd2;
              req_b[0] = CH_RPAREN;
              req_b[1] = CH_NUL;
            end
          end
        end else if (quotes_r) begin
          req_n    = 2'd1;
          req_b[0] = c;
        end else if (is_ws(c)) begin
          if (intok_r) begin
            req_n = 2'd1;
            if (depth_r != '0) begin
              req_b[0]     = CH_SPACE;
              collapse_nxt = 1'b1;
            end else begin
              it_w     = 1'b0;
              req_b[0] = CH_NUL;
              tc_w     = sat_inc(tokens_r);
            end
          end
        end else if (is_delim(c)) begin
          if (depth_r != '0) begin
            req_n    = 2'd1;
            req_b[0] = c;
          end else begin
            delim_path = 1'b1;
            it_w       = 1'b0;
            tc_w       = tc_mid;
            if (intok_r) begin
              delim_idx = 2'd1;
              req_n     = 2'd3;
              req_b[0]  = CH_NUL;
              req_b[1]  = c;
              req_b[2]  = CH_NUL;
            end else begin
              delim_idx = 2'd0;
              req_n     = 2'd2;
              req_b[0]  = c;
              req_b[1]  = CH_NUL;
            end
          end
        end else begin
          if (!intok_r) begin
            sp_w = tok_room;
            it_w = 1'b1;
          end
          req_n    = 2'd1;
          req_b[0] = c;
        end

        if (room >= LEN_W'(req_n)) begin
          nwr = req_n;
        end else begin
          nwr = room[1:0];
        end

        req_f[0] = (delim_path && (delim_idx == 2'd0)) ? dflag : sp_w;
        req_f[1] = delim_path && (delim_idx == 2'd1) && dflag;
        req_f[2] = 1'b0;

        if (delim_path && dflag && (nwr > delim_idx)) begin
          tc_w = sat_inc(tc_w);
        end

        startp_nxt  = (nwr != 2'd0) ? 1'b0 : sp_w;
        intok_nxt   = it_w;
        tokens_nxt  = tc_w;
        written_nxt = written_r + CNT_W'(nwr);
        res_n       = nwr;
        for (int i = 0; i < 3; i++) begin
          res[i].kind        = KIND_BYTE;
          res[i].out_byte    = req_b[i];
          res[i].token_start = req_f[i];
          res[i].status      = STATUS_OK;
          res[i].token_count = '0;
          res[i].last        = (2'(i) == (nwr - 2'd1));
        end
      end
    end
  end

  // Result queue.
  always_comb begin
    queue_nxt[0] = queue_r[0];
    queue_nxt[1] = queue_r[1];
    queue_nxt[2] = queue_r[2];
    qcnt_nxt     = qcnt_r;
    if (accept) begin
      queue_nxt[0] = res[0];
      queue_nxt[1] = res[1];
      queue_nxt[2] = res[2];
      qcnt_nxt     = res_n;
    end else if (pop) begin
      queue_nxt[0] = queue_r[1];
      queue_nxt[1] = queue_r[2];
      qcnt_nxt     = qcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    queue_r[0] <= queue_nxt[0];
    queue_r[1] <= queue_nxt[1];
    queue_r[2] <= queue_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r     <= 2'd0;
      quotes_r   <= 1'b0;
      esc_r      <= 1'b0;
      intok_r    <= 1'b0;
      startp_r   <= 1'b0;
      collapse_r <= 1'b0;
      depth_r    <= '0;
      written_r  <= '0;
      tokens_r   <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
      if (accept) begin
        quotes_r   <= quotes_nxt;
        esc_r      <= esc_nxt;
        intok_r    <= intok_nxt;
        startp_r   <= startp_nxt;
        collapse_r <= collapse_nxt;
        depth_r    <= depth_nxt;
        written_r  <= written_nxt;
        tokens_r   <= tokens_nxt;
      end
    end
  end

  // A pending token start always belongs to an open token.
  a_start_in_token: assert property (@(posedge clk) disable iff (!rst_n)
    startp_r |-> intok_r)
    else $error("token start pending outside a token");

  // A backslash escape is only ever armed inside a quoted string.
  a_esc_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> quotes_r)
    else $error("escape pending outside quotes");

  // Whitespace collapsing only happens inside a comment.
  a_collapse_in_comment: assert property (@(posedge clk) disable iff (!rst_n)
    collapse_r |-> (depth_r != '0))
    else $error("whitespace collapsing outside a comment");

  // Once the text is closed, the state is back at its reset values.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.end_of_text) |=> (written_r == '0) && (tokens_r == '0)
      && (depth_r == '0) && !quotes_r && !intok_r)
    else $error("state not cleared after end of text");

endmodule

`default_nettype wire

/* bench/hvt_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the header value tokenizer: watches the item and result
// channels and the register port, predicts every result and compares it.
// Depends on hvt_pkg for the payload types and character codes.
module hvt_token_checker (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  input  wire                         in_ready,
  input  hvt_pkg::in_item_t           in_data,
  input  wire                         out_valid,
  input  wire                         out_ready,
  input  hvt_pkg::result_t            out_data,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [hvt_pkg::PADDR_W-1:0] paddr,
  input  wire  [hvt_pkg::PDATA_W-1:0] pwdata,
  input  wire                         pready,
  output int                          fail_count,
  output int                          due_count
);
  import hvt_pkg::*;

  logic [LEN_W-1:0]  cfg_len;
  logic [MAXT_W-1:0] cfg_maxt;

  logic             quoting;
  logic             escaped;
  logic             in_word;
  logic             mark_next;
  logic             squeeze_ws;
  logic [CNT_W-1:0] paren_depth;
  logic [CNT_W-1:0] buf_fill;
  logic [CNT_W-1:0] token_total;

  result_t step_out [3];
  int      step_n;
  result_t tokens_due [$];
  int      mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [LEN_W-1:0] fill_limit();
    if (cfg_len > LEN_LIMIT) return LEN_LIMIT;
    if (cfg_len == '0) return LEN_W'(1);
    return cfg_len;
  endfunction

  function automatic logic [CNT_W-1:0] token_limit();
    if (cfg_maxt > MAXT_LIMIT) return CNT_W'(MAXT_LIMIT);
    return CNT_W'(cfg_maxt);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void clear_tokenizer();
    quoting     = 1'b0;
    escaped     = 1'b0;
    in_word     = 1'b0;
    mark_next   = 1'b0;
    squeeze_ws  = 1'b0;
    paren_depth = '0;
    buf_fill    = '0;
    token_total = '0;
  endfunction

  function automatic void push_result(input logic kind, input logic [7:0] b, input logic flag,
                                      input logic [1:0] st, input logic [CNT_W-1:0] cnt);
    result_t r;
    r             = '0;
    r.kind        = kind;
    r.out_byte    = b;
    r.token_start = flag;
    r.status      = st;
    r.token_count = cnt;
    if (step_n < 3) begin
      step_out[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic logic store_flagged(input logic [7:0] b, input logic flag);
    if (buf_fill >= fill_limit()) return 1'b0;
    push_result(KIND_BYTE, b, flag, STATUS_OK, '0);
    buf_fill++;
    return 1'b1;
  endfunction

  function automatic void store(input logic [7:0] b);
    if (buf_fill >= fill_limit()) return;
    void'(store_flagged(b, mark_next));
    mark_next = 1'b0;
  endfunction

  function automatic void bump_count();
    if (token_total != CNT_SAT) token_total++;
  endfunction

  function automatic void open_word();
    if (!in_word) begin
      if (token_total < token_limit()) mark_next = 1'b1;
      in_word = 1'b1;
    end
  endfunction

  function automatic void tokenize_text(input logic [7:0] c);
    logic flag;
    logic room;
    if (squeeze_ws) begin
      if (is_blank(c)) return;
      squeeze_ws = 1'b0;
    end
    if (buf_fill >= fill_limit()) return;
    if (escaped) begin
      open_word();
      if (c == CH_BSLASH || c == CH_QUOTE) store(CH_BSLASH);
      store(c);
      escaped = 1'b0;
    end else if (c == CH_BSLASH && quoting) begin
      escaped = 1'b1;
    end else if (c == CH_QUOTE && paren_depth == '0) begin
      quoting = !quoting;
      open_word();
    end else if (c == CH_LPAREN && !quoting) begin
      if (paren_depth != CNT_SAT) paren_depth++;
      open_word();
      store(c);
    end else if (c == CH_RPAREN && !quoting) begin
      if (paren_depth != '0) begin
        paren_depth--;
        if (paren_depth == '0) begin
          in_word = 1'b0;
          bump_count();
          store(CH_RPAREN);
          store(CH_NUL);
        end
      end
    end else if (quoting) begin
      store(c);
    end else if (is_blank(c)) begin
      if (in_word) begin
        if (paren_depth != '0) begin
          store(CH_SPACE);
          squeeze_ws = 1'b1;
        end else begin
          in_word = 1'b0;
          store(CH_NUL);
          bump_count();
        end
      end
    end else if (c == CH_SEMI || c == CH_EQUALS || c == CH_DOT) begin
      if (paren_depth != '0) begin
        store(c);
      end else begin
        if (in_word) begin
          in_word = 1'b0;
          store(CH_NUL);
          bump_count();
        end
        flag = token_total < token_limit();
        room = store_flagged(c, flag);
        if (room && flag) bump_count();
        store(CH_NUL);
      end
    end else begin
      open_word();
      store(c);
    end
  endfunction

  function automatic void finish_text();
    logic [1:0] st;
    if (quoting || paren_depth != '0) begin
      st = STATUS_UNBAL;
    end else if ({1'b0, buf_fill} + 14'd1 >= {1'b0, fill_limit()}) begin
      st = STATUS_OVFL;
    end else begin
      if (in_word) begin
        store(CH_NUL);
        bump_count();
      end
      st = STATUS_OK;
    end
    push_result(KIND_SUMMARY, CH_NUL, 1'b0, st, token_total);
    clear_tokenizer();
  endfunction

  function automatic void tokenize_item(input in_item_t it);
    step_n = 0;
    if (!it.end_of_text) tokenize_text(it.in_byte);
    else finish_text();
    if (step_n > 0) step_out[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) tokens_due.push_back(step_out[i]);
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      cfg_len  = LEN_RESET;
      cfg_maxt = MAXT_RESET;
      clear_tokenizer();
      tokens_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_BUFFER_LEN, 2'b00}) cfg_len = pwdata[LEN_W-1:0];
        else if (paddr == {REG_MAX_TOKENS, 2'b00}) cfg_maxt = pwdata[MAXT_W-1:0];
      end
      if (in_valid && in_ready) tokenize_item(in_data);
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          mismatches++;
          $error("result with none expected: kind %0d, out_byte %0d, status %0d",
                 out_data.kind, out_data.out_byte, out_data.status);
        end else begin
          want = tokens_due.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("token_start", want.token_start, out_data.token_start);
          check_field("status", want.status, out_data.status);
          check_field("token_count", want.token_count, out_data.token_count);
          check_field("last", want.last, out_data.last);
        end
      end
    end
    due_count <= tokens_due.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Top of the header value tokenizer bench: clock, reset, register writes,
// item stimulus with random bursts, result back-pressure and the verdict.
// Depends on hvt_pkg, header_value_tokenizer and hvt_token_checker.
module tb;
  import hvt_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 40;

  localparam logic [8:0] OPENING [26] = '{
    {8'h00, 1'b0}, {8'hFF, 1'b0}, {CH_SPACE, 1'b0}, {CH_EQUALS, 1'b0},
    {CH_QUOTE, 1'b0}, {CH_BSLASH, 1'b0}, {CH_QUOTE, 1'b0}, {CH_BSLASH, 1'b0},
    {CH_BSLASH, 1'b0}, {CH_BSLASH, 1'b0}, {8'h71, 1'b0}, {CH_QUOTE, 1'b0},
    {CH_LPAREN, 1'b0}, {8'h61, 1'b0}, {CH_SPACE, 1'b0}, {CH_TAB, 1'b0},
    {CH_LPAREN, 1'b0}, {CH_RPAREN, 1'b0}, {CH_DOT, 1'b0}, {CH_RPAREN, 1'b0},
    {CH_RPAREN, 1'b0}, {CH_QUOTE, 1'b0}, {CH_QUOTE, 1'b0}, {8'hA5, 1'b1},
    {CH_LPAREN, 1'b0}, {8'h5A, 1'b1}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  result_t            out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int due_count;
  int burst_left = 0;
  int sent = 0;
  int quiet = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int stall_left = 0;

  header_value_tokenizer dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hvt_token_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .due_count
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (ready_mode != 0 && $urandom_range(0, ready_mode == 1 ? 7 : 2) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("[header_value_tokenizer] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, end_of_text: eot};
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent++;
  endtask

  task automatic send_text(input logic [7:0] b);
    send_item(b, 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] ws_byte();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(9 + r);
  endfunction

  function automatic logic [7:0] delim_byte();
    case ($urandom_range(0, 2))
      0: return CH_SEMI;
      1: return CH_EQUALS;
      default: return CH_DOT;
    endcase
  endfunction

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(8'h30, 8'h39));
      4: return 8'($urandom_range(8'h41, 8'h5A));
      5: return 8'($urandom_range(8'h80, 8'hFF));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  function automatic logic [7:0] comment_byte();
    case ($urandom_range(0, 7))
      0, 1: return ws_byte();
      2: return delim_byte();
      3: return CH_QUOTE;
      4: return CH_BSLASH;
      default: return word_byte();
    endcase
  endfunction

  task automatic send_quoted();
    send_text(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0: begin
          send_text(CH_BSLASH);
          case ($urandom_range(0, 2))
            0: send_text(CH_BSLASH);
            1: send_text(CH_QUOTE);
            default: send_text(word_byte());
          endcase
        end
        1: send_text(ws_byte());
        2: send_text(8'($urandom_range(0, 255)));
        default: send_text(word_byte());
      endcase
    end
    if ($urandom_range(0, 7) != 0) send_text(CH_QUOTE);
  endtask

  task automatic send_comment();
    int depth;
    int closes;
    depth = $urandom_range(1, 3);
    repeat (depth) begin
      send_text(CH_LPAREN);
      repeat ($urandom_range(0, 3)) send_text(comment_byte());
    end
    closes = ($urandom_range(0, 7) == 0) ? depth - 1 : depth;
    repeat (closes) begin
      send_text(CH_RPAREN);
      if ($urandom_range(0, 2) == 0) send_text(comment_byte());
    end
  endtask

  task automatic send_header();
    if ($urandom_range(0, 29) == 0) drain();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        2: repeat ($urandom_range(1, 3)) send_text(ws_byte());
        3: send_text(delim_byte());
        4: send_quoted();
        5: send_comment();
        6: send_text(CH_RPAREN);
        7: send_text(8'($urandom_range(0, 255)));
        default: repeat ($urandom_range(1, 5)) send_text(word_byte());
      endcase
    end
    if ($urandom_range(0, 9) != 0) send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int len_val;
    int maxt_val;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (OPENING[i]) send_item(OPENING[i][8:1], OPENING[i][0]);
    for (int ph = 1; ph <= 8; ph++) begin
      drain();
      repeat (8) @(posedge clk);
      case (ph)
        1: begin len_val = 2; maxt_val = 1; end
        2: begin len_val = 4096; maxt_val = 1024; end
        3: begin len_val = 0; maxt_val = 0; end
        4: begin len_val = 8191; maxt_val = 2047; end
        5: begin len_val = 1; maxt_val = 3; end
        6: begin len_val = $urandom_range(2, 40); maxt_val = $urandom_range(0, 8); end
        7: begin len_val = $urandom_range(16, 400); maxt_val = $urandom_range(1, 1200); end
        default: begin len_val = $urandom_range(3, 12); maxt_val = $urandom_range(1, 4); end
      endcase
      write_reg(REG_BUFFER_LEN, len_val);
      write_reg(REG_MAX_TOKENS, maxt_val);
      sent = 0;
      while (sent < PHASE_ITEMS) send_header();
    end
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[header_value_tokenizer] OK");
    end else begin
      $display("[header_value_tokenizer] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/hvt_pkg.sv
rtl/core/header_value_tokenizer.sv
bench/hvt_checker.sv
bench/tb.sv
